### rtl/core/two_level_page_walker_defines.svh
// Assertion helpers for the page walker RTL.
// Each one samples on clk and is switched off while rst_n is low.
`ifndef TWO_LEVEL_PAGE_WALKER_DEFINES_SVH
`define TWO_LEVEL_PAGE_WALKER_DEFINES_SVH

// Same-cycle implication
`define TPW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define TPW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/tpw_pkg.sv
`timescale 1ns / 1ps

package tpw_pkg;

  // Input action codes
  localparam logic ACT_REQUEST  = 1'b0;
  localparam logic ACT_RESPONSE = 1'b1;

  // Result kinds
  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // Walk status codes
  localparam logic [1:0] ST_SUCCESS   = 2'd0;
  localparam logic [1:0] ST_INVALID   = 2'd1;
  localparam logic [1:0] ST_PAGED_OUT = 2'd2;

  // Presence profiles
  localparam logic [1:0] PROF_PLAIN   = 2'd0;
  localparam logic [1:0] PROF_LINUX   = 2'd1;
  localparam logic [1:0] PROF_WINDOWS = 2'd2;

  // Entry bit positions
  localparam int BIT_PRESENT = 0;
  localparam int BIT_LARGE   = 7;
  localparam int BIT_GLOBAL  = 8;
  localparam int BIT_PROTO   = 10;
  localparam int BIT_TRANS   = 11;

  // One decoded word waiting between front and back.
  // For a request, word holds the directory entry address;
  // for a response, word holds the returned entry.
  typedef struct packed {
    logic        is_resp;
    logic [31:0] va;
    logic [32:0] word;
  } tpw_entry_t;

  typedef struct packed {
    logic        result_kind;
    logic [32:0] read_address;
    logic [31:0] physical_address;
    logic [1:0]  walk_status;
  } tpw_result_t;

endpackage

### rtl/core/tpw_if.sv
`timescale 1ns / 1ps

interface tpw_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] virtual_address;
  logic [31:0] directory_base;
  logic [31:0] read_data;

  modport source (output valid, action, virtual_address, directory_base, read_data,
                  input ready);
  modport sink   (input valid, action, virtual_address, directory_base, read_data,
                  output ready);
endinterface

interface tpw_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [32:0] read_address;
  logic [31:0] physical_address;
  logic [1:0]  walk_status;

  modport source (output valid, result_kind, read_address, physical_address, walk_status,
                  input ready);
  modport sink   (input valid, result_kind, read_address, physical_address, walk_status,
                  output ready);
endinterface

interface tpw_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] paging_profile;

  modport source (output valid, paging_profile, input ready);
  modport sink   (input valid, paging_profile, output ready);
endinterface

### rtl/core/two_level_page_walker.sv
`timescale 1ns / 1ps
// Two-level 32-bit page table walker.
// in_ch carries words of two kinds: a translate request (virtual address and
// directory base) or a memory response (the 32-bit entry read). out_ch carries
// either a read request for the next entry or a finished translation with a
// status of success, invalid or paged out. cfg_ch writes the presence profile
// and is always ready; write it only while no walk is open.
// A request is answered by a directory read; feeding each read's data back as
// a response drives the walk on to a table read or to completion. Requests
// that arrive while a walk is open, and responses with no walk open, are
// dropped without a result.
// A result passes through two registers on its way to out_ch: first the queue,
// then the output register.
// Throughput: one word per cycle; the decode front feeds a QUEUE_DEPTH-entry
// queue and the walk step drains one entry per cycle into the output register.
// When the receiver stalls the output register holds, the queue fills and
// in_ch.ready drops once the queue is full.
// Reset (rst_n low, synchronous) empties the queue and output, closes any walk
// and sets the profile to plain.
module two_level_page_walker import tpw_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  tpw_in_if.sink    in_ch,
  tpw_out_if.source out_ch,
  tpw_cfg_if.sink   cfg_ch
);

  logic       push;
  logic       q_full;
  logic       q_valid;
  logic       pop;
  tpw_entry_t push_entry;
  tpw_entry_t q_entry;

  tpw_front u_front (
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  tpw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .pop_entry  (q_entry),
    .not_empty  (q_valid)
  );

  tpw_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .pop     (pop),
    .out_ch  (out_ch),
    .cfg_ch  (cfg_ch)
  );

endmodule

### rtl/core/tpw_front.sv
`timescale 1ns / 1ps

module tpw_front import tpw_pkg::*; (
  tpw_in_if.sink     in_ch,
  input  logic       q_full,
  output logic       push,
  output tpw_entry_t push_entry
);

  // Take a word whenever the queue has room
  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && in_ch.ready;

  // Classify and precompute the directory entry address for requests
  always_comb begin
    push_entry = '0;
    if (in_ch.action == ACT_REQUEST) begin
      push_entry.is_resp = 1'b0;
      push_entry.va      = in_ch.virtual_address;
      push_entry.word    = {1'b0, in_ch.directory_base} +
                           {21'b0, in_ch.virtual_address[31:22], 2'b00};
    end else begin
      push_entry.is_resp = 1'b1;
      push_entry.va      = '0;
      push_entry.word    = {1'b0, in_ch.read_data};
    end
  end

endmodule

### rtl/core/tpw_queue.sv
`timescale 1ns / 1ps

module tpw_queue import tpw_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  tpw_entry_t push_entry,
  output logic       full,
  input  logic       pop,
  output tpw_entry_t pop_entry,
  output logic       not_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tpw_entry_t          slots_r [DEPTH];
  logic [AW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]       count_r, count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_entry = slots_r[rd_ptr_r];

  // Advance pointers with wrap and track fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store incoming word
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

### rtl/core/tpw_back.sv
`timescale 1ns / 1ps
`include "two_level_page_walker_defines.svh"

module tpw_back import tpw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  tpw_entry_t q_entry,
  output logic       pop,
  tpw_out_if.source  out_ch,
  tpw_cfg_if.sink    cfg_ch
);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_DIR   = 3'b010,
    PH_TABLE = 3'b100
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [31:0] held_va_r, held_va_nxt;
  logic [1:0]  profile_r;
  logic        out_valid_r;
  tpw_result_t out_r;
  tpw_result_t res;
  logic        emit;
  logic        idle;
  logic [31:0] data;

  // Presence test under the selected profile; unknown profile acts as plain
  function automatic logic is_present(input logic [31:0] e, input logic [1:0] prof);
    logic p;
    logic trans;
    logic glob;
    p     = e[BIT_PRESENT];
    trans = e[BIT_TRANS] && !e[BIT_PROTO];
    glob  = e[BIT_GLOBAL];
    if (prof == PROF_LINUX) begin
      return p || glob;
    end else if (prof == PROF_WINDOWS) begin
      return p || trans;
    end
    return p;
  endfunction

  // Configuration is always taken
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      profile_r <= PROF_PLAIN;
    end else if (cfg_ch.valid) begin
      profile_r <= cfg_ch.paging_profile;
    end
  end

  // Pop whenever the output register is free or being drained
  assign pop  = q_valid && (!out_valid_r || out_ch.ready);
  assign idle = !(phase_r == PH_DIR || phase_r == PH_TABLE);
  assign data = q_entry.word[31:0];

  // Walk step for the word at the queue head
  always_comb begin
    emit        = 1'b0;
    res         = '0;
    phase_nxt   = phase_r;
    held_va_nxt = held_va_r;
    if (pop) begin
      if (!q_entry.is_resp) begin
        // New request: only taken when no walk is open
        if (idle) begin
          emit             = 1'b1;
          res.result_kind  = KIND_READ;
          res.read_address = q_entry.word;
          held_va_nxt      = q_entry.va;
          phase_nxt        = PH_DIR;
        end
      end else begin
        unique case (phase_r)
          PH_DIR: begin
            emit      = 1'b1;
            phase_nxt = PH_IDLE;
            res.result_kind = KIND_DONE;
            if (!is_present(data, profile_r)) begin
              res.walk_status = data[BIT_LARGE] ? ST_PAGED_OUT : ST_INVALID;
            end else if (data[BIT_LARGE]) begin
              res.walk_status      = ST_SUCCESS;
              res.physical_address = {data[31:22], held_va_r[21:0]};
            end else begin
              // Go on to the page table entry
              res.result_kind  = KIND_READ;
              res.read_address = {1'b0, data[31:12], held_va_r[21:12], 2'b00};
              phase_nxt        = PH_TABLE;
            end
          end
          PH_TABLE: begin
            emit            = 1'b1;
            phase_nxt       = PH_IDLE;
            res.result_kind = KIND_DONE;
            if (!is_present(data, profile_r)) begin
              res.walk_status = ST_PAGED_OUT;
            end else begin
              res.walk_status      = ST_SUCCESS;
              res.physical_address = {data[31:12], held_va_r[11:0]};
            end
          end
          default: begin
            // Response with no walk open: drop
            emit = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      held_va_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      held_va_r <= held_va_nxt;
      if (!out_valid_r || out_ch.ready) begin
        out_valid_r <= pop && emit;
      end
    end
  end

  // Load result word
  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_r <= res;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.result_kind      = out_r.result_kind;
  assign out_ch.read_address     = out_r.read_address;
  assign out_ch.physical_address = out_r.physical_address;
  assign out_ch.walk_status      = out_r.walk_status;

  `TPW_ASSERT_NOW(a_no_pop_while_stalled, out_valid_r && !out_ch.ready, !pop,
    "back popped while a result was stalled")
  `TPW_ASSERT_NEXT(a_done_closes_walk, pop && emit && res.result_kind == KIND_DONE,
    phase_r == PH_IDLE, "finished walk left phase open")
  `TPW_ASSERT_NEXT(a_resp_read_to_table,
    pop && emit && q_entry.is_resp && res.result_kind == KIND_READ,
    phase_r == PH_TABLE, "table read issued without entering table phase")
  `TPW_ASSERT_NOW(a_fail_has_no_pa,
    out_valid_r && out_r.result_kind == KIND_DONE && out_r.walk_status != ST_SUCCESS,
    out_r.physical_address == '0, "failed walk carries a physical address")

endmodule
